// ===== hdl/spf_pkg.sv =====
package spf_pkg;

  localparam int BYTE_W          = 8;
  localparam int CNT_W           = 6;
  localparam int MAX_PAYLOAD_DEF = 51;

  localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'hFF;
  localparam logic [BYTE_W-1:0] CK_MASK   = 8'hFE;
  localparam logic [BYTE_W-1:0] SIZE_BIAS = 8'd7;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_SEND   = 1'b1;

  // Source of the byte loaded into the output register.
  typedef enum logic [2:0] {
    SEL_ZERO = 3'd0,
    SEL_HDR  = 3'd1,
    SEL_SIZE = 3'd2,
    SEL_ID   = 3'd3,
    SEL_CMD  = 3'd4,
    SEL_CK1  = 3'd5,
    SEL_CK2  = 3'd6,
    SEL_PAY  = 3'd7
  } sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic append;
    logic latch;
    logic out_load;
    sel_t sel;
    logic last;
    logic ovf;
    logic idx_inc;
    logic clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic full;
    logic count_zero;
    logic pay_last;
  } stat_t;

endpackage

// ===== hdl/spf_ctrl.sv =====
module spf_ctrl
  import spf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_action,
  input  stat_t stat,
  output logic  in_stall,
  output cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_HDR2 = 8'b0000_0010,
    ST_SIZE = 8'b0000_0100,
    ST_ID   = 8'b0000_1000,
    ST_CMD  = 8'b0001_0000,
    ST_CK1  = 8'b0010_0000,
    ST_CK2  = 8'b0100_0000,
    ST_PAY  = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    cmd.sel   = SEL_ZERO;
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = !stat.out_free;
        if (in_valid && stat.out_free) begin
          if (in_action == ACT_SEND) begin
            cmd.latch    = 1'b1;
            cmd.out_load = 1'b1;
            cmd.sel      = SEL_HDR;
            state_nxt    = ST_HDR2;
          end else if (stat.full) begin
            cmd.out_load = 1'b1;
            cmd.sel      = SEL_ZERO;
            cmd.last     = 1'b1;
            cmd.ovf      = 1'b1;
          end else begin
            cmd.append = 1'b1;
          end
        end
      end
      ST_HDR2: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.sel      = SEL_HDR;
          state_nxt    = ST_SIZE;
        end
      end
      ST_SIZE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.sel      = SEL_SIZE;
          state_nxt    = ST_ID;
        end
      end
      ST_ID: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.sel      = SEL_ID;
          state_nxt    = ST_CMD;
        end
      end
      ST_CMD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.sel      = SEL_CMD;
          state_nxt    = ST_CK1;
        end
      end
      ST_CK1: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.sel      = SEL_CK1;
          state_nxt    = ST_CK2;
        end
      end
      ST_CK2: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.sel      = SEL_CK2;
          cmd.last     = stat.count_zero;
          if (stat.count_zero) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_PAY;
          end
        end
      end
      ST_PAY: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.sel      = SEL_PAY;
          cmd.last     = stat.pay_last;
          if (stat.pay_last) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/spf_dp.sv =====
module spf_dp
  import spf_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] in_payload_byte,
  input  logic [BYTE_W-1:0] in_dest_id,
  input  logic [BYTE_W-1:0] in_command,
  input  cmd_t              cmd,
  input  logic              out_stall,
  output stat_t             stat,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last,
  output logic              out_overflow
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0] rd_data_r;

  logic [CNT_W-1:0]  count_r;
  logic [BYTE_W-1:0] xor_r;
  logic [AW-1:0]     idx_r;
  logic [AW-1:0]     idx_nxt;

  logic [BYTE_W-1:0] id_r;
  logic [BYTE_W-1:0] command_r;
  logic [BYTE_W-1:0] size_r;
  logic [BYTE_W-1:0] ck1_r;
  logic [BYTE_W-1:0] size_nxt;
  logic [BYTE_W-1:0] ck1_nxt;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              out_ovf_r;
  logic [BYTE_W-1:0] out_byte_nxt;

  assign size_nxt = BYTE_W'(count_r) + SIZE_BIAS;
  assign ck1_nxt  = (size_nxt ^ in_dest_id ^ in_command ^ xor_r) & CK_MASK;

  // The read address runs one step ahead so that rd_data_r always holds
  // the entry at idx_r, even across stalls.
  always_comb begin
    if (cmd.clear) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + AW'(1);
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_HDR:  out_byte_nxt = HDR_BYTE;
      SEL_SIZE: out_byte_nxt = size_r;
      SEL_ID:   out_byte_nxt = id_r;
      SEL_CMD:  out_byte_nxt = command_r;
      SEL_CK1:  out_byte_nxt = ck1_r;
      SEL_CK2:  out_byte_nxt = (~ck1_r) & CK_MASK;
      SEL_PAY:  out_byte_nxt = rd_data_r;
      default:  out_byte_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[count_r[AW-1:0]] <= in_payload_byte;
    end
    rd_data_r <= mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      id_r      <= in_dest_id;
      command_r <= in_command;
      size_r    <= size_nxt;
      ck1_r     <= ck1_nxt;
    end
    if (cmd.out_load) begin
      out_byte_r <= out_byte_nxt;
      out_last_r <= cmd.last;
      out_ovf_r  <= cmd.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      xor_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (cmd.clear) begin
        count_r <= '0;
        xor_r   <= '0;
      end else if (cmd.append) begin
        count_r <= count_r + CNT_W'(1);
        xor_r   <= xor_r ^ in_payload_byte;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_free   = !out_valid_r || !out_stall;
  assign stat.full       = count_r >= CNT_W'(MAX_PAYLOAD);
  assign stat.count_zero = count_r == '0;
  assign stat.pay_last   = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PAYLOAD))
    else $error("payload count above store depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.out_load)
    else $error("output register loaded while a transfer is pending");

  a_ovf_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ovf |=> ($stable(count_r) && $stable(xor_r)))
    else $error("refused append changed the payload state");

  a_pay_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && (cmd.sel == SEL_PAY)) |-> (CNT_W'(idx_r) < count_r))
    else $error("payload read beyond stored bytes");
`endif

endmodule

// ===== hdl/servo_packet_framer_core.sv =====
// Append: a transfer gives no result; a refused append into a full store puts
// one error result in the output register on the next cycle.
// Send: the first header byte is in the output register the cycle after the transfer, and
// a packet of 7 + n bytes leaves at one byte per cycle while the receiver does not stall;
// the next item is taken once the last byte is loaded.
// Synchronous active-low reset empties the store and clears the running XOR and out_valid.
module servo_packet_framer_core
  import spf_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [BYTE_W-1:0] in_payload_byte,
  input  logic [BYTE_W-1:0] in_dest_id,
  input  logic [BYTE_W-1:0] in_command,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last,
  output logic              out_overflow
);

  // The controller walks the packet fields in order, one per output transfer slot.
  // The datapath holds the payload memory, the byte count, the running XOR of the
  // payload, the header fields latched at the send transfer and the output register.
  // The output register frees its slot in the same cycle that a transfer takes it,
  // so bytes stream back to back as long as the receiver does not stall.

  cmd_t  cmd;
  stat_t stat;

  spf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .stat      (stat),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  spf_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_payload_byte (in_payload_byte),
    .in_dest_id      (in_dest_id),
    .in_command      (in_command),
    .cmd             (cmd),
    .out_stall       (out_stall),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_overflow    (out_overflow)
  );

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spf_pkg::*;

  // One request presented on the input channel.
  typedef struct {
    logic              action;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] dest_id;
    logic [BYTE_W-1:0] command;
  } framer_req_t;

  // One byte expected on the result channel, with its flags.
  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              overflow;
  } frame_byte_t;

  // The cycle budget assumes every request yields a full 58-byte packet, each byte waiting
  // out the longest stall burst, plus the sender's gaps. The budget is that worst case
  // taken about five times over.
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int REQ_TARGET   = 280;
  localparam int DRAIN_CYCLES = 20;
  localparam int PRINT_CAP    = 40;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_action = ACT_APPEND;
  logic [BYTE_W-1:0] in_payload_byte = '0;
  logic [BYTE_W-1:0] in_dest_id = '0;
  logic [BYTE_W-1:0] in_command = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic              out_overflow;

  // Requests waiting to be driven, and bytes the framer still owes us.
  framer_req_t pending_reqs[$];
  frame_byte_t expected_bytes[$];

  // Our own copy of the framer's state: stored payload, its count and running XOR.
  logic [BYTE_W-1:0] payload_mem [MAX_PAYLOAD_DEF];
  logic [CNT_W-1:0]  payload_cnt;
  logic [BYTE_W-1:0] payload_xor;

  int cycle_cnt = 0;
  int error_count = 0;
  int reqs_accepted = 0;
  int packets_framed = 0;
  int full_packets = 0;
  int refusals = 0;
  int bytes_checked = 0;
  int gap_left = 0;
  int stall_left = 0;

  // While bits 7:6 of the cycle count are zero, no new idle gap or stall burst is started.
  logic calm;
  assign calm = (cycle_cnt[7:6] == 2'b00);

  servo_packet_framer_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_payload_byte (in_payload_byte),
    .in_dest_id      (in_dest_id),
    .in_command      (in_command),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_overflow    (out_overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Idle and stall lengths. Most are zero, many are short and a few are long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic void queue_req(logic act, logic [BYTE_W-1:0] pb,
                                    logic [BYTE_W-1:0] id, logic [BYTE_W-1:0] cmd);
    pending_reqs.push_back('{action: act, payload_byte: pb, dest_id: id, command: cmd});
  endfunction

  function automatic void owe_byte(logic [BYTE_W-1:0] b, logic l, logic ovf);
    expected_bytes.push_back('{data: b, last: l, overflow: ovf});
  endfunction

  // Advance our copy of the framer by one accepted request. Push every byte it must send.
  // An append into a full store is refused with a single zero byte that has last and
  // overflow set. A send emits the two header bytes, then size, id, command and both
  // checksums. The stored payload follows. The final byte of the packet carries last.
  task automatic frame_request(input logic act, input logic [BYTE_W-1:0] pb,
                               input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] cmd);
    logic [BYTE_W-1:0] size_b;
    logic [BYTE_W-1:0] ck1;
    logic [BYTE_W-1:0] ck2;
    int n;
    if (act == ACT_APPEND) begin
      if (payload_cnt >= MAX_PAYLOAD_DEF) begin
        owe_byte('0, 1'b1, 1'b1);
        refusals++;
      end else begin
        payload_mem[payload_cnt] = pb;
        payload_cnt = payload_cnt + 1'b1;
        payload_xor = payload_xor ^ pb;
      end
    end else begin
      n = payload_cnt;
      size_b = BYTE_W'(n) + SIZE_BIAS;
      ck1 = (size_b ^ id ^ cmd ^ payload_xor) & CK_MASK;
      ck2 = ~ck1 & CK_MASK;
      owe_byte(HDR_BYTE, 1'b0, 1'b0);
      owe_byte(HDR_BYTE, 1'b0, 1'b0);
      owe_byte(size_b, 1'b0, 1'b0);
      owe_byte(id, 1'b0, 1'b0);
      owe_byte(cmd, 1'b0, 1'b0);
      owe_byte(ck1, 1'b0, 1'b0);
      // With nothing stored, the second checksum closes the packet.
      owe_byte(ck2, n == 0, 1'b0);
      for (int i = 0; i < n; i++) begin
        owe_byte(payload_mem[i], i == n - 1, 1'b0);
      end
      payload_cnt = '0;
      payload_xor = '0;
      packets_framed++;
      if (n == MAX_PAYLOAD_DEF) full_packets++;
    end
  endtask

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("tb: mismatch at cycle %0d: %s", cycle_cnt, msg);
  endtask

  task automatic check_frame_byte(input logic [BYTE_W-1:0] b, input logic l, input logic ovf);
    frame_byte_t want;
    if (expected_bytes.size() == 0) begin
      flag_error($sformatf("unexpected byte %02h last %0b overflow %0b", b, l, ovf));
      return;
    end
    want = expected_bytes.pop_front();
    bytes_checked++;
    if (b !== want.data)
      flag_error($sformatf("byte %02h, expected %02h", b, want.data));
    if (l !== want.last)
      flag_error($sformatf("last %0b, expected %0b on byte %02h", l, want.last, want.data));
    if (ovf !== want.overflow)
      flag_error($sformatf("overflow %0b, expected %0b on byte %02h", ovf, want.overflow,
                           want.data));
  endtask

  // Driver. Each transfer seen at this edge goes into the prediction first. Then the next
  // request is loaded, or an idle gap is inserted. Nothing changes while the framer stalls
  // us. Idle cycles carry junk in the data fields, because the framer must ignore them.
  always @(posedge clk) begin : drive_proc
    framer_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      payload_cnt = '0;
      payload_xor = '0;
    end else begin
      if (in_valid && !in_stall) begin
        frame_request(in_action, in_payload_byte, in_dest_id, in_command);
        reqs_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || pending_reqs.size() == 0) begin
          if (gap_left > 0) gap_left <= gap_left - 1;
          in_valid <= 1'b0;
          in_action <= 1'($urandom);
          in_payload_byte <= BYTE_W'($urandom);
          in_dest_id <= BYTE_W'($urandom);
          in_command <= BYTE_W'($urandom);
        end else begin
          req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_action <= req.action;
          in_payload_byte <= req.payload_byte;
          in_dest_id <= req.dest_id;
          in_command <= req.command;
          gap_left <= pick_gap();
        end
      end
    end
  end

  // Monitor. Every byte accepted from the framer is checked against the oldest expected
  // byte. The stall toward the framer is raised at random, in bursts of random length.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) check_frame_byte(out_byte, out_last, out_overflow);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        out_stall <= 1'b1;
        stall_left <= pick_gap();
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Cycle count and the hard stop.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: timed out with %0d bytes still expected", expected_bytes.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus_proc
    int r;
    int n_app;
    bit first_run;

    // Directed part. It covers sends with an empty store and a one-byte packet to the
    // broadcast id. It covers the extreme byte values and junk in the fields that each
    // action ignores. An empty send right after a non-empty send checks that sending clears the store.
    queue_req(ACT_SEND, 8'hFF, 8'h00, 8'h00);
    queue_req(ACT_SEND, 8'h00, 8'hFF, 8'hFF);
    queue_req(ACT_APPEND, 8'hFF, 8'hFF, 8'hFF);
    queue_req(ACT_SEND, 8'h00, 8'hFE, 8'h07);
    queue_req(ACT_APPEND, 8'h00, 8'h00, 8'h00);
    queue_req(ACT_APPEND, 8'hA5, 8'h5A, 8'hA5);
    queue_req(ACT_APPEND, 8'h5A, 8'hA5, 8'h5A);
    queue_req(ACT_SEND, 8'hFF, 8'h01, 8'h80);
    queue_req(ACT_APPEND, 8'h80, 8'h00, 8'hFF);
    queue_req(ACT_APPEND, 8'h01, 8'hFF, 8'h00);
    queue_req(ACT_SEND, 8'h55, 8'h7F, 8'h01);
    queue_req(ACT_SEND, 8'hAA, 8'hFE, 8'h0F);

    // Random part. The traffic is mostly append runs closed by a send. The first run, and
    // an occasional later one, fills the store and then runs past the end, so those
    // appends are refused. Some sends are skipped, which lets a run pile onto the previous
    // one. Some sends come with an empty store.
    first_run = 1'b1;
    while (pending_reqs.size() < REQ_TARGET) begin
      r = $urandom_range(0, 99);
      if (first_run || r < 8) n_app = MAX_PAYLOAD_DEF + $urandom_range(1, 3);
      else if (r < 20) n_app = 0;
      else if (r < 30) n_app = $urandom_range(9, 30);
      else n_app = $urandom_range(1, 8);
      first_run = 1'b0;
      for (int i = 0; i < n_app; i++) begin
        queue_req(ACT_APPEND, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
      end
      if ($urandom_range(0, 9) != 0) begin
        queue_req(ACT_SEND, BYTE_W'($urandom),
                  ($urandom_range(0, 7) == 0) ? 8'hFE : BYTE_W'($urandom),
                  BYTE_W'($urandom));
      end
    end

    // Reset is held at the start and released once.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every request has been taken, then until every owed byte has come back.
    // After that, keep the clock running for DRAIN_CYCLES to show any byte it should not send.
    do @(negedge clk); while (pending_reqs.size() != 0 || in_valid);
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_bytes.size() != 0)
      flag_error($sformatf("%0d expected bytes never arrived", expected_bytes.size()));

    $display("tb: %0d requests, %0d packets (%0d with a full store), %0d refused appends",
             reqs_accepted, packets_framed, full_packets, refusals);
    $display("tb: %0d result bytes checked, %0d mismatches", bytes_checked, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
